// File: design/pbo_pkg.sv
package pbo_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int COORD_W   = 12;
	localparam int DIM_W     = 13;
	localparam int OFF_W     = 13;
	localparam int WEIGHT_W  = 9;
	localparam int IDX_W     = 24;
	localparam int CH_W      = 8;
	localparam int NUM_CH    = 4;
	localparam int CH_TONE   = 3;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int WEIGHT_ONE = 256;

	localparam int IN_DATA_W  = 2 * COORD_W + 2 * NUM_CH * CH_W;
	localparam int OUT_DATA_W = IDX_W + NUM_CH * CH_W;

	typedef enum logic [2:0] {
		MODE_OVERLAY = 3'd0,
		MODE_MASK    = 3'd1,
		MODE_INVMASK = 3'd2,
		MODE_MAX     = 3'd3,
		MODE_LERP    = 3'd4,
		MODE_MULT    = 3'd5
	} blend_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLEND_MODE    = 3'd0,
		REG_LERP_WEIGHT   = 3'd1,
		REG_OFFSET_X      = 3'd2,
		REG_OFFSET_Y      = 3'd3,
		REG_TARGET_WIDTH  = 3'd4,
		REG_TARGET_HEIGHT = 3'd5
	} reg_idx_t;

	// channel 0 red, 1 green, 2 blue, 3 tone
	typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

	typedef struct packed {
		blend_mode_t               mode;
		logic [WEIGHT_W-1:0]       weight;
		logic signed [OFF_W-1:0]   off_x;
		logic signed [OFF_W-1:0]   off_y;
		logic [DIM_W-1:0]          width;
		logic [DIM_W-1:0]          height;
	} cfg_t;

endpackage

// File: design/pixel_blend_with_offset.sv
// An accepted input transaction passes the input register, then the result register, to m_axis.
// Throughput: one pixel per cycle unless m_axis stalls; the whole blend and placement run
// in one pass between the input register and the result register (one 12x13 index multiply).
// The result register stalls independently; while a result waits, an empty input register takes input.
// Reset: arst_n clears both valid flags and restores the register reset values.
module pixel_blend_with_offset (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [pbo_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [pbo_pkg::CFG_W-1:0]       wr_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// src_x, src_y, src_red, src_green, src_blue, src_tone,
	// tgt_red, tgt_green, tgt_blue, tgt_tone
	input  logic [pbo_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// target_index, out_red, out_green, out_blue, out_tone
	output logic [pbo_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// in_range
	output logic                            m_axis_tuser
);
	import pbo_pkg::*;

	localparam int PIX_W = NUM_CH * CH_W;

	cfg_t cfg;

	logic               v_s1, v_s2;
	logic               adv_s1, adv_s2;
	logic [COORD_W-1:0] src_x_s1, src_y_s1;
	pix_t               src_s1, tgt_s1;

	logic [IDX_W-1:0]   index_c;
	logic               range_c;
	pix_t               res_c;

	logic [IDX_W-1:0]   index_s2;
	logic               range_s2;
	pix_t               res_s2;

	pbo_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	pbo_place u_place (
		.src_x        (src_x_s1),
		.src_y        (src_y_s1),
		.cfg          (cfg),
		.target_index (index_c),
		.in_range     (range_c)
	);

	pbo_blend u_blend (
		.tgt    (tgt_s1),
		.src    (src_s1),
		.mode   (cfg.mode),
		.weight (cfg.weight),
		.res    (res_c)
	);

	assign adv_s2        = !v_s2 || m_axis_tready;
	assign adv_s1        = !v_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				v_s1 <= s_axis_tvalid;
			if (adv_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && adv_s1) begin
			src_x_s1 <= s_axis_tdata[COORD_W-1:0];
			src_y_s1 <= s_axis_tdata[2*COORD_W-1:COORD_W];
			src_s1   <= s_axis_tdata[2*COORD_W+PIX_W-1:2*COORD_W];
			tgt_s1   <= s_axis_tdata[2*COORD_W+2*PIX_W-1:2*COORD_W+PIX_W];
		end
		if (v_s1 && adv_s2) begin
			index_s2 <= index_c;
			range_s2 <= range_c;
			res_s2   <= res_c;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {res_s2, index_s2};
	assign m_axis_tuser  = range_s2;

	// input only stalls when both stages hold data and the sink is stalled
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && v_s2 && !m_axis_tready))
		else $error("input stalled with room in the pipeline");

	a_oob_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[IDX_W-1:0] == '0))
		else $error("out-of-range pixel with non-zero index");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> v_s1)
		else $error("accepted transaction lost at input stage");

endmodule

// File: design/pbo_cfg.sv
module pbo_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [pbo_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [pbo_pkg::CFG_W-1:0]      wr_data,
	output pbo_pkg::cfg_t                  cfg
);
	import pbo_pkg::*;

	cfg_t cfg_q;
	logic [WEIGHT_W-1:0] weight_sat;
	logic [DIM_W-1:0]    dim_sat;

	// saturate on write; only the clamped values are ever used
	always_comb begin
		if (32'(wr_data[WEIGHT_W-1:0]) > WEIGHT_ONE)
			weight_sat = WEIGHT_W'(WEIGHT_ONE);
		else
			weight_sat = wr_data[WEIGHT_W-1:0];
		if (32'(wr_data[DIM_W-1:0]) > MAX_DIM)
			dim_sat = DIM_W'(MAX_DIM);
		else
			dim_sat = wr_data[DIM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= MODE_OVERLAY;
			cfg_q.weight <= WEIGHT_W'(128);
			cfg_q.off_x  <= '0;
			cfg_q.off_y  <= '0;
			cfg_q.width  <= DIM_W'(256);
			cfg_q.height <= DIM_W'(256);
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_BLEND_MODE:    cfg_q.mode   <= blend_mode_t'(wr_data[2:0]);
				REG_LERP_WEIGHT:   cfg_q.weight <= weight_sat;
				REG_OFFSET_X:      cfg_q.off_x  <= $signed(wr_data[OFF_W-1:0]);
				REG_OFFSET_Y:      cfg_q.off_y  <= $signed(wr_data[OFF_W-1:0]);
				REG_TARGET_WIDTH:  cfg_q.width  <= dim_sat;
				REG_TARGET_HEIGHT: cfg_q.height <= dim_sat;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/pbo_place.sv
module pbo_place (
	input  logic [pbo_pkg::COORD_W-1:0] src_x,
	input  logic [pbo_pkg::COORD_W-1:0] src_y,
	input  pbo_pkg::cfg_t               cfg,
	output logic [pbo_pkg::IDX_W-1:0]   target_index,
	output logic                        in_range
);
	import pbo_pkg::*;

	localparam int POS_W  = OFF_W + 1;
	localparam int PROD_W = COORD_W + DIM_W;

	logic signed [POS_W-1:0] px, py;
	logic                    x_ok, y_ok;
	logic [PROD_W-1:0]       lin;

	always_comb begin
		px = $signed({{(POS_W-COORD_W){1'b0}}, src_x}) + POS_W'(cfg.off_x);
		py = $signed({{(POS_W-COORD_W){1'b0}}, src_y}) + POS_W'(cfg.off_y);
		x_ok = !px[POS_W-1] && (px[DIM_W-1:0] < cfg.width);
		y_ok = !py[POS_W-1] && (py[DIM_W-1:0] < cfg.height);
		in_range = x_ok && y_ok;
		// inside the target both coordinates fit in COORD_W bits
		lin = PROD_W'(py[COORD_W-1:0]) * PROD_W'(cfg.width)
		    + PROD_W'(px[COORD_W-1:0]);
		target_index = in_range ? lin[IDX_W-1:0] : '0;
	end

endmodule

// File: design/pbo_blend.sv
module pbo_blend (
	input  pbo_pkg::pix_t                tgt,
	input  pbo_pkg::pix_t                src,
	input  pbo_pkg::blend_mode_t         mode,
	input  logic [pbo_pkg::WEIGHT_W-1:0] weight,
	output pbo_pkg::pix_t                res
);
	import pbo_pkg::*;

	localparam int SUM_W = CH_W + WEIGHT_W;

	logic                src_wins;
	logic [WEIGHT_W-1:0] inv_w;
	logic [SUM_W-1:0]    mix [NUM_CH];
	logic [SUM_W-1:0]    prod [NUM_CH];
	logic [SUM_W-1:0]    quot [NUM_CH];

	always_comb begin
		src_wins = src[CH_TONE] > tgt[CH_TONE];
		inv_w    = WEIGHT_W'(WEIGHT_ONE) - weight;
		for (int i = 0; i < NUM_CH; i++) begin
			mix[i]  = SUM_W'(tgt[i]) * SUM_W'(inv_w) + SUM_W'(src[i]) * SUM_W'(weight);
			prod[i] = SUM_W'(tgt[i]) * SUM_W'(src[i]);
			// floor(p/255) for p below 2^16
			quot[i] = prod[i] + (prod[i] >> CH_W) + SUM_W'(1);
			case (mode)
				MODE_OVERLAY: res[i] = src[i];
				MODE_MASK:    res[i] = src_wins ? tgt[i] : src[i];
				MODE_INVMASK: res[i] = src_wins ? src[i] : tgt[i];
				MODE_MAX:     res[i] = (tgt[i] > src[i]) ? tgt[i] : src[i];
				MODE_LERP:    res[i] = mix[i][2*CH_W-1:CH_W];
				MODE_MULT:    res[i] = quot[i][2*CH_W-1:CH_W];
				default:      res[i] = tgt[i];
			endcase
		end
	end

endmodule
